FILE: hdl/bhpq_pkg.sv
// Shared types and codes for the binary heap priority queue.
package bhpq_pkg;

  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  localparam logic [2:0] REG_MAX_FIRST = 3'd0;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_PUSH,
    OP_POP
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [1:0]         status;
    logic signed [31:0] value;
  } job_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_POP_ROOT,
    ST_POP_LAST,
    ST_POP_LOAD,
    ST_DN_RDL,
    ST_DN_RDR,
    ST_DN_CMP,
    ST_DONE
  } eng_state_t;

endpackage

FILE: hdl/bhpq_front.sv
// Front end: takes commands, tracks the entry count and classifies each job.
module bhpq_front import bhpq_pkg::*; #(
  parameter int CAPACITY = 64,
  parameter int CW       = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         command,
  input  logic signed [31:0] value,
  output logic               q_valid,
  input  logic               q_ready,
  output job_t               q_job,
  output logic [CW-1:0]      q_count
);

  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;

  assign in_ready = q_ready;
  assign q_valid  = in_valid;

  always_comb begin
    cnt_next     = cnt;
    q_job.op     = OP_NONE;
    q_job.status = STAT_OK;
    q_job.value  = value;
    unique case (command)
      CMD_PUSH: begin
        if (cnt == CAP_CNT) begin
          q_job.status = STAT_FULL;
        end else begin
          q_job.op = OP_PUSH;
          cnt_next = cnt + 1'b1;
        end
      end
      CMD_POP: begin
        if (cnt == '0) begin
          q_job.status = STAT_EMPTY;
        end else begin
          q_job.op = OP_POP;
          cnt_next = cnt - 1'b1;
        end
      end
      CMD_CLEAR: begin
        cnt_next = '0;
      end
      default: begin
      end
    endcase
  end

  // count after this job travels with it to the back end
  assign q_count = cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (in_valid && q_ready) begin
      cnt <= cnt_next;
    end
  end

endmodule

FILE: hdl/bhpq_fifo.sv
// Two-entry job queue between front and back end.
module bhpq_fifo #(
  parameter int W = 43
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);

  logic [W-1:0] slots [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   fill;
  logic         do_wr;
  logic         do_rd;

  assign wr_ready = (fill != 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rd_data  = slots[rptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (do_wr) begin
        wptr <= ~wptr;
      end
      if (do_rd) begin
        rptr <= ~rptr;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 2'd1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wptr] <= wr_data;
    end
  end

endmodule

FILE: hdl/bhpq_engine.sv
// Back end: heap memory, sift-up/sift-down sequencer and result register.
module bhpq_engine import bhpq_pkg::*; #(
  parameter int CAPACITY = 64,
  parameter int CW       = 7,
  parameter int AW       = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               max_first,
  input  logic               job_valid,
  output logic               job_ready,
  input  job_t               job,
  input  logic [CW-1:0]      job_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] top_value,
  output logic [CW-1:0]      entry_count,
  output logic [1:0]         status
);

  eng_state_t state;
  eng_state_t state_next;

  logic signed [31:0] store [CAPACITY];
  logic signed [31:0] rdata;
  logic [AW-1:0]      raddr;
  logic               we;
  logic [AW-1:0]      waddr;
  logic signed [31:0] wdata;

  logic [CW-1:0]      pos;
  logic [CW-1:0]      pos_next;
  logic [CW-1:0]      held;
  logic [CW-1:0]      held_next;
  logic [1:0]         res_status;
  logic [1:0]         res_status_next;
  logic signed [31:0] top;
  logic signed [31:0] top_next;
  logic signed [31:0] cur;
  logic signed [31:0] cur_next;
  logic signed [31:0] lval;
  logic signed [31:0] lval_next;
  logic               load_out;

  logic [CW-1:0] pos_m1;
  logic [CW-1:0] parent;
  logic [CW-1:0] parent_m1;
  logic [CW:0]   left;
  logic [CW:0]   right;
  logic [CW:0]   left_m1;
  logic [CW:0]   right_m1;
  logic          has_left;
  logic          has_right;
  logic          take_l;
  logic          take_r;
  logic signed [31:0] best_a;

  function automatic logic ranks_above(input logic mf, input logic signed [31:0] a,
                                       input logic signed [31:0] b);
    logic r;
    r = mf ? (a > b) : (a < b);
    return r;
  endfunction

  assign pos_m1    = pos - 1'b1;
  assign parent    = pos >> 1;
  assign parent_m1 = parent - 1'b1;
  assign left      = {pos, 1'b0};
  assign right     = {pos, 1'b1};
  assign left_m1   = left - 1'b1;
  assign right_m1  = right - 1'b1;
  assign has_left  = (left <= {1'b0, held});
  assign has_right = (right <= {1'b0, held});
  assign take_l    = ranks_above(max_first, lval, cur);
  assign best_a    = take_l ? lval : cur;
  assign take_r    = has_right && ranks_above(max_first, rdata, best_a);

  assign job_ready = (state == ST_IDLE);

  always_comb begin
    state_next      = state;
    pos_next        = pos;
    held_next       = held;
    res_status_next = res_status;
    top_next        = top;
    cur_next        = cur;
    lval_next       = lval;
    raddr           = '0;
    we              = 1'b0;
    waddr           = pos_m1[AW-1:0];
    wdata           = cur;
    load_out        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (job_valid) begin
          held_next       = job_count;
          res_status_next = job.status;
          top_next        = '0;
          cur_next        = job.value;
          pos_next        = job_count;
          unique case (job.op)
            OP_PUSH: state_next = ST_UP_RD;
            OP_POP:  state_next = ST_POP_ROOT;
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_UP_RD: begin
        if (pos == CW'(1)) begin
          we         = 1'b1;
          state_next = ST_DONE;
        end else begin
          raddr      = parent_m1[AW-1:0];
          state_next = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        we = 1'b1;
        if (ranks_above(max_first, cur, rdata)) begin
          // parent moves down into the hole
          wdata      = rdata;
          pos_next   = parent;
          state_next = ST_UP_RD;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_POP_ROOT: begin
        raddr      = '0;
        state_next = ST_POP_LAST;
      end
      ST_POP_LAST: begin
        top_next = rdata;
        // last entry sat one past the new count
        raddr    = held[AW-1:0];
        if (held == '0) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_POP_LOAD;
        end
      end
      ST_POP_LOAD: begin
        cur_next   = rdata;
        pos_next   = CW'(1);
        state_next = ST_DN_RDL;
      end
      ST_DN_RDL: begin
        if (has_left) begin
          raddr      = left_m1[AW-1:0];
          state_next = ST_DN_RDR;
        end else begin
          we         = 1'b1;
          state_next = ST_DONE;
        end
      end
      ST_DN_RDR: begin
        lval_next  = rdata;
        raddr      = right_m1[AW-1:0];
        state_next = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        we = 1'b1;
        priority if (take_r) begin
          wdata      = rdata;
          pos_next   = right[CW-1:0];
          state_next = ST_DN_RDL;
        end else if (take_l) begin
          wdata      = lval;
          pos_next   = left[CW-1:0];
          state_next = ST_DN_RDL;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos        <= pos_next;
    held       <= held_next;
    res_status <= res_status_next;
    top        <= top_next;
    cur        <= cur_next;
    lval       <= lval_next;
    if (load_out) begin
      top_value   <= top;
      entry_count <= held;
      status      <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
    rdata <= store[raddr];
  end

`ifndef SYNTHESIS
  a_up_not_root: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UP_CMP) |-> (pos > CW'(1)))
    else $error("sift-up compare at root");

  a_dn_in_heap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DN_RDL || state == ST_DN_RDR || state == ST_DN_CMP)
      |-> (pos != '0 && pos <= held))
    else $error("sift-down position outside heap");

  a_dn_left_exists: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DN_RDR) |-> $past(has_left))
    else $error("left child read without a left child");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && (!out_valid || out_ready)) |=> (out_valid && state == ST_IDLE))
    else $error("result not registered on completion");
`endif

endmodule

FILE: hdl/binary_heap_priority_queue.sv
// Binary heap priority queue: a min- or max-heap of signed 32-bit values.
// Input channel (in_valid/in_ready): command 0 pushes value, 1 pops the top,
// 2 clears the heap. Every command gives exactly one result on the output
// channel (out_valid/out_ready): top_value (popped value, else 0), entry_count
// (entries held after the command) and status (0 ok, 1 pop on empty heap,
// 2 push on full heap, value dropped).
// The APB register at address 0 holds max_first: 0 smallest on top, 1 largest.
// A front end tracks the count and classifies each command into a two-entry
// job queue; a back end runs the sift on a single-port-read heap memory.
// In the back end a push reads and compares the parent for each level climbed,
// moving the parent down, and writes the value where it stops; a pop reads the
// root and, if entries remain, the last entry, then for each level descended
// reads the left and right children, compares and writes where it settles;
// other commands go straight to the result.
// Commands are taken while a result waits; when the receiver stalls, the
// back end holds its finished result and the queue fills, then in_ready falls.
// Reset empties the heap and sets max_first to 0; no clearing pass is needed.
module binary_heap_priority_queue import bhpq_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          command,
  input  logic signed [31:0]                  value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [31:0]                  top_value,
  output logic [$clog2(CAPACITY+1)-1:0]       entry_count,
  output logic [1:0]                          status,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int QW = $bits(job_t) + CW;

  logic          max_first;
  logic          f_valid;
  logic          f_ready;
  job_t          f_job;
  logic [CW-1:0] f_count;
  logic          b_valid;
  logic          b_ready;
  logic [QW-1:0] b_data;
  job_t          b_job;
  logic [CW-1:0] b_count;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_MAX_FIRST) ? {31'd0, max_first} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_first <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr == REG_MAX_FIRST) begin
      max_first <= pwdata[0];
    end
  end

  bhpq_front #(
    .CAPACITY (CAPACITY),
    .CW       (CW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .command  (command),
    .value    (value),
    .q_valid  (f_valid),
    .q_ready  (f_ready),
    .q_job    (f_job),
    .q_count  (f_count)
  );

  bhpq_fifo #(
    .W (QW)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  ({f_job, f_count}),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (b_data)
  );

  assign b_job   = b_data[QW-1:CW];
  assign b_count = b_data[CW-1:0];

  bhpq_engine #(
    .CAPACITY (CAPACITY),
    .CW       (CW),
    .AW       (AW)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .max_first   (max_first),
    .job_valid   (b_valid),
    .job_ready   (b_ready),
    .job         (b_job),
    .job_count   (b_count),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .top_value   (top_value),
    .entry_count (entry_count),
    .status      (status)
  );

endmodule
